[rtl/rieu_pkg.sv]
`timescale 1ns / 1ps
package rieu_pkg;

    localparam int MemWords = 4096;
    localparam int MemAw    = $clog2(MemWords);

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLT = 6'd2, OP_SLTU = 6'd3, OP_NOR = 6'd4,
        OP_AND = 6'd5, OP_OR = 6'd6, OP_XOR = 6'd7, OP_SLL = 6'd8, OP_SRL = 6'd9,
        OP_SRA = 6'd10, OP_MUL = 6'd11, OP_MULH = 6'd12, OP_MULHU = 6'd13,
        OP_DIV = 6'd14, OP_MOD = 6'd15, OP_DIVU = 6'd16, OP_MODU = 6'd17,
        OP_BREAK = 6'd18, OP_SYSCALL = 6'd19, OP_SLLI = 6'd20, OP_SRLI = 6'd21,
        OP_SRAI = 6'd22, OP_SLTI = 6'd23, OP_SLTUI = 6'd24, OP_ADDI = 6'd25,
        OP_ANDI = 6'd26, OP_NOP = 6'd27, OP_ORI = 6'd28, OP_XORI = 6'd29,
        OP_LDB = 6'd30, OP_LDH = 6'd31, OP_LDW = 6'd32, OP_STB = 6'd33,
        OP_STH = 6'd34, OP_STW = 6'd35, OP_LDBU = 6'd36, OP_LDHU = 6'd37,
        OP_PRELD = 6'd38, OP_LL = 6'd39, OP_SC = 6'd40, OP_JIRL = 6'd41,
        OP_B = 6'd42, OP_BL = 6'd43, OP_BEQ = 6'd44, OP_BNE = 6'd45,
        OP_BLT = 6'd46, OP_BGE = 6'd47, OP_BLTU = 6'd48, OP_BGEU = 6'd49,
        OP_LU12I = 6'd50, OP_PCADDU12I = 6'd51
    } t_op;

    localparam logic [1:0] TrapNone    = 2'd0;
    localparam logic [1:0] TrapBreak   = 2'd1;
    localparam logic [1:0] TrapSyscall = 2'd2;

    localparam logic CfgStart = 1'b0;

    typedef struct packed {
        logic [5:0]  command;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg_a;
        logic [4:0]  src_reg_b;
        logic [25:0] immediate;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        redirect;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic [1:0]  trap;
        logic        at_breakpoint;
    } t_out_item;

    typedef struct packed {
        logic [31:0] index;
        logic [31:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        is_signed;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } t_mdu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mdu_rsp;

endpackage

[rtl/rieu_if.sv]
`timescale 1ns / 1ps
interface rieu_in_if;
    logic                valid;
    logic                ready;
    rieu_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rieu_out_if;
    logic                valid;
    logic                ready;
    rieu_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rieu_cfg_if;
    logic                valid;
    logic                ready;
    rieu_pkg::t_cfg_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/rieu_mdu.sv]
`timescale 1ns / 1ps
module rieu_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rieu_pkg::t_mdu_req i_req,
    output rieu_pkg::t_mdu_rsp o_rsp
);

    // Shift-and-add multiply on the raw operands, restoring divide on magnitudes when signed.
    logic [31:0] r_b, r_q;
    logic [32:0] r_acc;
    logic [5:0]  r_cnt;
    logic        r_busy, r_div, r_neg_q, r_neg_r, r_done;
    logic [32:0] w_sum, w_trial;
    logic [31:0] w_abs_a, w_abs_b, w_rem;
    logic [63:0] w_prod;

    assign w_abs_a = (i_req.is_signed && i_req.op_a[31]) ? 32'd0 - i_req.op_a : i_req.op_a;
    assign w_abs_b = (i_req.is_signed && i_req.op_b[31]) ? 32'd0 - i_req.op_b : i_req.op_b;
    assign w_sum   = r_acc + (r_q[0] ? {1'b0, r_b} : 33'd0);
    assign w_trial = {r_acc[31:0], r_q[31]} - {1'b0, r_b};
    assign w_prod  = {r_acc[31:0], r_q};
    assign w_rem   = r_acc[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 6'd0;
                r_div   <= i_req.is_div;
                r_b     <= i_req.is_div ? w_abs_b : i_req.op_b;
                r_q     <= i_req.is_div ? w_abs_a : i_req.op_a;
                r_acc   <= 33'd0;
                r_neg_q <= i_req.is_signed && (i_req.op_a[31] ^ i_req.op_b[31]);
                r_neg_r <= i_req.is_signed && i_req.op_a[31];
            end else if (r_busy) begin
                if (r_div) begin
                    if (!w_trial[32]) begin
                        r_acc <= {1'b0, w_trial[31:0]};
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[31:0], r_q[31]};
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                end else begin
                    r_acc <= {1'b0, w_sum[32:1]};
                    r_q   <= {w_sum[0], r_q[31:1]};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_div) begin
            o_rsp.result = {r_neg_r ? 32'd0 - w_rem : w_rem,
                            r_neg_q ? 32'd0 - r_q : r_q};
        end else begin
            o_rsp.result = w_prod;
        end
    end

endmodule

[rtl/risc_integer_execute_unit_core.sv]
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in       sink       command, dest_reg, src_reg_a, src_reg_b, immediate
// out      source     next_pc, redirect, reg_write, reg_index, reg_value,
//                     mem_write, mem_address, mem_data, trap, at_breakpoint
// cfg      sink       index, data
// Simple operations, loads and stores pass through S_READ, S_MEM and S_EXEC to S_OUT;
// multiply and divide pass through S_MDU in place of S_MEM, waiting on the 32-step shared unit.
// After reset a clearing pass sweeps all 4096 words of the data memory.
// A held result stalls the block; the next item can be taken once the block is back in
// S_IDLE after the result leaves, and only while no cfg write is pending.
module risc_integer_execute_unit_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rieu_in_if.sink    in_ch,
    rieu_out_if.source out_ch,
    rieu_cfg_if.sink   cfg_ch
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MEM, S_MDU, S_EXEC, S_OUT
    } t_state;

    t_state r_state;
    rieu_pkg::t_in_item  r_item;
    rieu_pkg::t_out_item r_out;
    rieu_pkg::t_mdu_req  w_req;
    rieu_pkg::t_mdu_rsp  w_rsp;
    logic [31:0] r_rf [32];
    logic [31:0] r_mem [rieu_pkg::MemWords];
    logic [31:0] r_pc, r_bp, r_vd, r_vj, r_vk, r_mword, r_mdu_res;
    logic [rieu_pkg::MemAw-1:0] r_clr;
    logic r_mdu_go;

    rieu_pkg::t_op w_op;
    logic [31:0] w_si12, w_ui12, w_addr, w_a14, w_o16, w_o26, w_u20, w_pc4;
    logic [4:0]  w_sh;
    logic [31:0] w_val, w_npc, w_mdata, w_maddr;
    logic        w_wreg, w_wmem, w_taken;
    logic [1:0]  w_trap;
    logic [4:0]  w_widx;
    logic [31:0] w_eaddr;
    logic [rieu_pkg::MemAw-1:0] w_widx_mem;
    logic        w_mdu_op;

    assign w_op   = rieu_pkg::t_op'(r_item.command);
    assign w_si12 = {{20{r_item.immediate[11]}}, r_item.immediate[11:0]};
    assign w_ui12 = {20'd0, r_item.immediate[11:0]};
    assign w_addr = r_vj + w_si12;
    assign w_a14  = r_vj + {{16{r_item.immediate[13]}}, r_item.immediate[13:0], 2'b00};
    assign w_o16  = {{14{r_item.immediate[15]}}, r_item.immediate[15:0], 2'b00};
    assign w_o26  = {{4{r_item.immediate[25]}}, r_item.immediate[25:0], 2'b00};
    assign w_u20  = {r_item.immediate[19:0], 12'd0};
    assign w_pc4  = r_pc + 32'd4;
    assign w_sh   = {w_addr[1:0], 3'b000};
    assign w_eaddr = (w_op == rieu_pkg::OP_LL || w_op == rieu_pkg::OP_SC) ? w_a14 : w_addr;
    assign w_widx_mem = w_eaddr[rieu_pkg::MemAw+1:2];
    assign w_mdu_op = (r_item.command >= rieu_pkg::OP_MUL)
                   && (r_item.command <= rieu_pkg::OP_MODU);

    assign w_req.start     = r_mdu_go;
    assign w_req.is_div    = r_item.command >= rieu_pkg::OP_DIV;
    assign w_req.is_signed = w_op == rieu_pkg::OP_DIV || w_op == rieu_pkg::OP_MOD
                          || w_op == rieu_pkg::OP_MULH;
    assign w_req.op_a      = r_vj;
    assign w_req.op_b      = r_vk;

    rieu_mdu u_mdu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        logic [31:0] v8, v16;
        v8  = r_mword >> w_sh;
        v16 = r_mword >> {w_sh[4], 4'd0};
        w_val = 32'd0; w_npc = w_pc4; w_taken = 1'b0; w_wmem = 1'b0;
        w_maddr = 32'd0; w_mdata = 32'd0; w_trap = rieu_pkg::TrapNone;
        w_widx = r_item.dest_reg; w_wreg = 1'b0;
        unique case (w_op)
            rieu_pkg::OP_ADD:  begin w_wreg = 1'b1; w_val = r_vj + r_vk; end
            rieu_pkg::OP_SUB:  begin w_wreg = 1'b1; w_val = r_vj - r_vk; end
            rieu_pkg::OP_SLT:  begin w_wreg = 1'b1; w_val = {31'd0, $signed(r_vj) < $signed(r_vk)}; end
            rieu_pkg::OP_SLTU: begin w_wreg = 1'b1; w_val = {31'd0, r_vj < r_vk}; end
            rieu_pkg::OP_NOR:  begin w_wreg = 1'b1; w_val = ~(r_vj | r_vk); end
            rieu_pkg::OP_AND:  begin w_wreg = 1'b1; w_val = r_vj & r_vk; end
            rieu_pkg::OP_OR:   begin w_wreg = 1'b1; w_val = r_vj | r_vk; end
            rieu_pkg::OP_XOR:  begin w_wreg = 1'b1; w_val = r_vj ^ r_vk; end
            rieu_pkg::OP_SLL:  begin w_wreg = 1'b1; w_val = r_vj << r_vk[4:0]; end
            rieu_pkg::OP_SRL:  begin w_wreg = 1'b1; w_val = r_vj >> r_vk[4:0]; end
            rieu_pkg::OP_SRA:  begin w_wreg = 1'b1; w_val = 32'($signed(r_vj) >>> r_vk[4:0]); end
            rieu_pkg::OP_MUL, rieu_pkg::OP_MULH, rieu_pkg::OP_MULHU, rieu_pkg::OP_DIV,
            rieu_pkg::OP_MOD, rieu_pkg::OP_DIVU, rieu_pkg::OP_MODU: begin
                w_wreg = 1'b1; w_val = r_mdu_res;
            end
            rieu_pkg::OP_BREAK:   w_trap = rieu_pkg::TrapBreak;
            rieu_pkg::OP_SYSCALL: w_trap = rieu_pkg::TrapSyscall;
            rieu_pkg::OP_SLLI: begin w_wreg = 1'b1; w_val = r_vj << r_item.immediate[4:0]; end
            rieu_pkg::OP_SRLI: begin w_wreg = 1'b1; w_val = r_vj >> r_item.immediate[4:0]; end
            rieu_pkg::OP_SRAI: begin
                w_wreg = 1'b1; w_val = 32'($signed(r_vj) >>> r_item.immediate[4:0]);
            end
            rieu_pkg::OP_SLTI:  begin w_wreg = 1'b1; w_val = {31'd0, $signed(r_vj) < $signed(w_si12)}; end
            rieu_pkg::OP_SLTUI: begin w_wreg = 1'b1; w_val = {31'd0, r_vj < w_si12}; end
            rieu_pkg::OP_ADDI:  begin w_wreg = 1'b1; w_val = r_vj + w_si12; end
            rieu_pkg::OP_ANDI:  begin w_wreg = 1'b1; w_val = r_vj & w_ui12; end
            rieu_pkg::OP_ORI:   begin w_wreg = 1'b1; w_val = r_vj | w_ui12; end
            rieu_pkg::OP_XORI:  begin w_wreg = 1'b1; w_val = r_vj ^ w_ui12; end
            rieu_pkg::OP_LDB:  begin w_wreg = 1'b1; w_val = {{24{v8[7]}}, v8[7:0]}; end
            rieu_pkg::OP_LDH:  begin w_wreg = 1'b1; w_val = {{16{v16[15]}}, v16[15:0]}; end
            rieu_pkg::OP_LDW, rieu_pkg::OP_LL: begin w_wreg = 1'b1; w_val = r_mword; end
            rieu_pkg::OP_LDBU: begin w_wreg = 1'b1; w_val = {24'd0, v8[7:0]}; end
            rieu_pkg::OP_LDHU: begin w_wreg = 1'b1; w_val = {16'd0, v16[15:0]}; end
            rieu_pkg::OP_STB: begin
                w_wmem = 1'b1; w_maddr = w_addr;
                w_mdata = (r_mword & ~(32'hFF << w_sh)) | ({24'd0, r_vd[7:0]} << w_sh);
            end
            rieu_pkg::OP_STH: begin
                w_wmem = 1'b1; w_maddr = {w_addr[31:1], 1'b0};
                w_mdata = (r_mword & ~(32'hFFFF << {w_sh[4], 4'd0}))
                        | ({16'd0, r_vd[15:0]} << {w_sh[4], 4'd0});
            end
            rieu_pkg::OP_STW: begin
                w_wmem = 1'b1; w_maddr = {w_addr[31:2], 2'b00}; w_mdata = r_vd;
            end
            rieu_pkg::OP_SC: begin
                w_wmem = 1'b1; w_maddr = {w_a14[31:2], 2'b00}; w_mdata = r_vd;
                w_wreg = 1'b1; w_val = 32'd1;
            end
            rieu_pkg::OP_JIRL: begin
                w_wreg = 1'b1; w_val = w_pc4; w_npc = r_vj + w_o16; w_taken = 1'b1;
            end
            rieu_pkg::OP_B:  begin w_npc = r_pc + w_o26; w_taken = 1'b1; end
            rieu_pkg::OP_BL: begin
                w_wreg = 1'b1; w_widx = 5'd1; w_val = w_pc4;
                w_npc = r_pc + w_o26; w_taken = 1'b1;
            end
            rieu_pkg::OP_BEQ:  w_taken = r_vd == r_vj;
            rieu_pkg::OP_BNE:  w_taken = r_vd != r_vj;
            rieu_pkg::OP_BLT:  w_taken = $signed(r_vd) < $signed(r_vj);
            rieu_pkg::OP_BGE:  w_taken = $signed(r_vd) >= $signed(r_vj);
            rieu_pkg::OP_BLTU: w_taken = r_vd < r_vj;
            rieu_pkg::OP_BGEU: w_taken = r_vd >= r_vj;
            rieu_pkg::OP_LU12I:      begin w_wreg = 1'b1; w_val = w_u20; end
            rieu_pkg::OP_PCADDU12I:  begin w_wreg = 1'b1; w_val = r_pc + w_u20; end
            default: ;
        endcase
        if (r_item.command >= rieu_pkg::OP_BEQ && r_item.command <= rieu_pkg::OP_BGEU
                && w_taken) begin
            w_npc = r_pc + w_o16;
        end
        if (w_widx == 5'd0) begin
            w_wreg = 1'b0;
        end
        if (!w_wreg) begin
            w_widx = 5'd0; w_val = 32'd0;
        end
    end

    assign in_ch.ready  = (r_state == S_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready = r_state == S_IDLE || r_state == S_CLEAR;
    assign out_ch.valid = r_state == S_OUT;
    assign out_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr] <= 32'd0;
        end else if (r_state == S_EXEC && w_wmem) begin
            r_mem[w_maddr[rieu_pkg::MemAw+1:2]] <= w_mdata;
        end
        if (r_state == S_READ) begin
            r_mword <= r_mem[w_widx_mem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= 32'd0;
            r_bp     <= 32'd0;
            r_mdu_go <= 1'b0;
            for (int i = 0; i < 32; i++) r_rf[i] <= 32'd0;
        end else begin
            r_mdu_go <= 1'b0;
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.payload.index[31:1] == 31'd0) begin
                if (cfg_ch.payload.index[0] == rieu_pkg::CfgStart) r_pc <= cfg_ch.payload.data;
                else r_bp <= cfg_ch.payload.data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == rieu_pkg::MemAw'(rieu_pkg::MemWords - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_item <= in_ch.payload;
                        r_vd <= r_rf[in_ch.payload.dest_reg];
                        r_vj <= r_rf[in_ch.payload.src_reg_a];
                        r_vk <= r_rf[in_ch.payload.src_reg_b];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_mdu_op) begin
                        r_mdu_go <= 1'b1;
                        r_state <= S_MDU;
                    end else begin
                        r_state <= S_MEM;
                    end
                end
                S_MDU: begin
                    if (w_rsp.done) begin
                        unique case (w_op)
                            rieu_pkg::OP_MUL: r_mdu_res <= w_rsp.result[31:0];
                            rieu_pkg::OP_MULH: r_mdu_res <= w_rsp.result[63:32]
                                - (r_vj[31] ? r_vk : 32'd0) - (r_vk[31] ? r_vj : 32'd0);
                            rieu_pkg::OP_MULHU: r_mdu_res <= w_rsp.result[63:32];
                            rieu_pkg::OP_DIV, rieu_pkg::OP_DIVU:
                                r_mdu_res <= (r_vk == 32'd0) ? 32'hFFFF_FFFF : w_rsp.result[31:0];
                            default:
                                r_mdu_res <= (r_vk == 32'd0) ? r_vj : w_rsp.result[63:32];
                        endcase
                        r_state <= S_EXEC;
                    end
                end
                S_MEM: r_state <= S_EXEC;
                S_EXEC: begin
                    r_out.next_pc       <= w_npc;
                    r_out.redirect      <= w_taken;
                    r_out.reg_write     <= w_wreg;
                    r_out.reg_index     <= w_widx;
                    r_out.reg_value     <= w_val;
                    r_out.mem_write     <= w_wmem;
                    r_out.mem_address   <= w_wmem ? w_maddr : 32'd0;
                    r_out.mem_data      <= w_wmem ? w_mdata : 32'd0;
                    r_out.trap          <= w_trap;
                    r_out.at_breakpoint <= w_npc == r_bp;
                    if (w_wreg) r_rf[w_widx] <= w_val;
                    r_pc <= w_npc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/rieu_checker.sv]
`timescale 1ns / 1ps
module rieu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_reg_write,
    input logic [4:0] i_reg_index,
    input logic i_mem_write,
    input logic [31:0] i_mem_address
);

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken while result pending");
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready) else $error("ready after accept");
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_reg_write |-> i_reg_index != 5'd0) else $error("r0 written");
    a_idx0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reg_write |-> i_reg_index == 5'd0) else $error("stale index");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mem_write)
        && $stable(i_mem_address)) else $error("result dropped");

endmodule

bind risc_integer_execute_unit_core rieu_checker u_rieu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_reg_write(out_ch.payload.reg_write), .i_reg_index(out_ch.payload.reg_index),
    .i_mem_write(out_ch.payload.mem_write), .i_mem_address(out_ch.payload.mem_address)
);

[sim/risc_integer_execute_unit_core_tb.sv]
`timescale 1ns / 1ps
module risc_integer_execute_unit_core_tb;

    localparam logic [31:0] REG_START_ADDR = 32'd0;
    localparam logic [31:0] REG_BREAK_ADDR = 32'd1;
    localparam int          STALL_LIMIT    = 20000;
    localparam int          DRAIN_CYCLES   = 50;

    logic i_clk;
    logic i_rst_n;

    rieu_in_if  in_if ();
    rieu_out_if out_if ();
    rieu_cfg_if cfg_if ();

    risc_integer_execute_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .cfg_ch  (cfg_if)
    );

    // Shadow copy of the architectural state.
    logic [31:0] gpr [32];
    logic [31:0] dmem [rieu_pkg::MemWords];
    logic [31:0] pc_q;
    logic [31:0] brk_addr_q;

    rieu_pkg::t_out_item pending_results [$];
    int          error_count;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(2, 1);
        if (r < 95) return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [31:0] word_of(logic [31:0] addr);
        return dmem[addr[rieu_pkg::MemAw+1:2]];
    endfunction

    function automatic logic [31:0] div_s(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ua, ub, q, r;
        if (b == 32'd0) return want_rem ? a : 32'hFFFF_FFFF;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        r  = ua % ub;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Executes one item on the shadow state and returns the expected result.
    function automatic rieu_pkg::t_out_item execute_item(rieu_pkg::t_in_item it);
        rieu_pkg::t_out_item res;
        logic [31:0] vd, vj, vk, si12, ui12, addr, addr_w, word, npc, wval, maddr, mdata;
        logic [31:0] off14, off16, off26, hi20;
        logic [63:0] prod;
        logic [4:0]  sh, widx;
        logic [1:0]  trap;
        bit          wreg, wmem, taken, cond;
        vd    = gpr[it.dest_reg];
        vj    = gpr[it.src_reg_a];
        vk    = gpr[it.src_reg_b];
        si12  = {{20{it.immediate[11]}}, it.immediate[11:0]};
        ui12  = {20'd0, it.immediate[11:0]};
        off14 = {{16{it.immediate[13]}}, it.immediate[13:0], 2'b00};
        off16 = {{14{it.immediate[15]}}, it.immediate[15:0], 2'b00};
        off26 = {{4{it.immediate[25]}}, it.immediate[25:0], 2'b00};
        hi20  = {it.immediate[19:0], 12'd0};
        addr  = vj + si12;
        addr_w = vj + off14;
        sh    = {addr[1:0], 3'b000};
        word  = word_of(addr);
        npc   = pc_q + 32'd4;
        wval  = 32'd0;
        maddr = 32'd0;
        mdata = 32'd0;
        widx  = it.dest_reg;
        trap  = rieu_pkg::TrapNone;
        wreg  = 1'b0;
        wmem  = 1'b0;
        taken = 1'b0;
        cond  = 1'b0;
        case (it.command)
            rieu_pkg::OP_ADD:   begin wreg = 1; wval = vj + vk; end
            rieu_pkg::OP_SUB:   begin wreg = 1; wval = vj - vk; end
            rieu_pkg::OP_SLT:   begin wreg = 1; wval = {31'd0, $signed(vj) < $signed(vk)}; end
            rieu_pkg::OP_SLTU:  begin wreg = 1; wval = {31'd0, vj < vk}; end
            rieu_pkg::OP_NOR:   begin wreg = 1; wval = ~(vj | vk); end
            rieu_pkg::OP_AND:   begin wreg = 1; wval = vj & vk; end
            rieu_pkg::OP_OR:    begin wreg = 1; wval = vj | vk; end
            rieu_pkg::OP_XOR:   begin wreg = 1; wval = vj ^ vk; end
            rieu_pkg::OP_SLL:   begin wreg = 1; wval = vj << vk[4:0]; end
            rieu_pkg::OP_SRL:   begin wreg = 1; wval = vj >> vk[4:0]; end
            rieu_pkg::OP_SRA:   begin wreg = 1; wval = $signed(vj) >>> vk[4:0]; end
            rieu_pkg::OP_MUL:   begin wreg = 1; wval = vj * vk; end
            rieu_pkg::OP_MULH: begin
                wreg = 1;
                prod = $signed({{32{vj[31]}}, vj}) * $signed({{32{vk[31]}}, vk});
                wval = prod[63:32];
            end
            rieu_pkg::OP_MULHU: begin
                wreg = 1;
                prod = {32'd0, vj} * {32'd0, vk};
                wval = prod[63:32];
            end
            rieu_pkg::OP_DIV:   begin wreg = 1; wval = div_s(vj, vk, 1'b0); end
            rieu_pkg::OP_MOD:   begin wreg = 1; wval = div_s(vj, vk, 1'b1); end
            rieu_pkg::OP_DIVU:  begin wreg = 1; wval = (vk != 0) ? vj / vk : 32'hFFFF_FFFF; end
            rieu_pkg::OP_MODU:  begin wreg = 1; wval = (vk != 0) ? vj % vk : vj; end
            rieu_pkg::OP_BREAK: trap = rieu_pkg::TrapBreak;
            rieu_pkg::OP_SYSCALL: trap = rieu_pkg::TrapSyscall;
            rieu_pkg::OP_SLLI:  begin wreg = 1; wval = vj << it.immediate[4:0]; end
            rieu_pkg::OP_SRLI:  begin wreg = 1; wval = vj >> it.immediate[4:0]; end
            rieu_pkg::OP_SRAI:  begin wreg = 1; wval = $signed(vj) >>> it.immediate[4:0]; end
            rieu_pkg::OP_SLTI:  begin wreg = 1; wval = {31'd0, $signed(vj) < $signed(si12)}; end
            rieu_pkg::OP_SLTUI: begin wreg = 1; wval = {31'd0, vj < si12}; end
            rieu_pkg::OP_ADDI:  begin wreg = 1; wval = vj + si12; end
            rieu_pkg::OP_ANDI:  begin wreg = 1; wval = vj & ui12; end
            rieu_pkg::OP_ORI:   begin wreg = 1; wval = vj | ui12; end
            rieu_pkg::OP_XORI:  begin wreg = 1; wval = vj ^ ui12; end
            rieu_pkg::OP_LDB:   begin wreg = 1; wval = 32'($signed(8'(word >> sh))); end
            rieu_pkg::OP_LDH: begin
                wreg = 1; wval = 32'($signed(16'(word >> (sh & 5'd16))));
            end
            rieu_pkg::OP_LDW:   begin wreg = 1; wval = word; end
            rieu_pkg::OP_LDBU:  begin wreg = 1; wval = {24'd0, 8'(word >> sh)}; end
            rieu_pkg::OP_LDHU:  begin wreg = 1; wval = {16'd0, 16'(word >> (sh & 5'd16))}; end
            rieu_pkg::OP_STB: begin
                wmem  = 1;
                maddr = addr;
                mdata = (word & ~(32'hFF << sh)) | ({24'd0, vd[7:0]} << sh);
            end
            rieu_pkg::OP_STH: begin
                wmem  = 1;
                maddr = {addr[31:1], 1'b0};
                mdata = (word & ~(32'hFFFF << (sh & 5'd16)))
                      | ({16'd0, vd[15:0]} << (sh & 5'd16));
            end
            rieu_pkg::OP_STW: begin
                wmem  = 1;
                maddr = {addr[31:2], 2'b00};
                mdata = vd;
            end
            rieu_pkg::OP_LL:    begin wreg = 1; wval = word_of(addr_w); end
            rieu_pkg::OP_SC: begin
                wmem  = 1;
                maddr = {addr_w[31:2], 2'b00};
                mdata = vd;
                wreg  = 1;
                wval  = 32'd1;
            end
            rieu_pkg::OP_JIRL: begin
                wreg  = 1;
                wval  = pc_q + 32'd4;
                npc   = vj + off16;
                taken = 1;
            end
            rieu_pkg::OP_B: begin
                npc   = pc_q + off26;
                taken = 1;
            end
            rieu_pkg::OP_BL: begin
                wreg  = 1;
                widx  = 5'd1;
                wval  = pc_q + 32'd4;
                npc   = pc_q + off26;
                taken = 1;
            end
            rieu_pkg::OP_BEQ, rieu_pkg::OP_BNE, rieu_pkg::OP_BLT, rieu_pkg::OP_BGE,
            rieu_pkg::OP_BLTU, rieu_pkg::OP_BGEU: begin
                case (it.command)
                    rieu_pkg::OP_BEQ:  cond = (vd == vj);
                    rieu_pkg::OP_BNE:  cond = (vd != vj);
                    rieu_pkg::OP_BLT:  cond = $signed(vd) < $signed(vj);
                    rieu_pkg::OP_BGE:  cond = $signed(vd) >= $signed(vj);
                    rieu_pkg::OP_BLTU: cond = vd < vj;
                    default: cond = vd >= vj;
                endcase
                if (cond) begin
                    npc   = pc_q + off16;
                    taken = 1;
                end
            end
            rieu_pkg::OP_LU12I:      begin wreg = 1; wval = hi20; end
            rieu_pkg::OP_PCADDU12I:  begin wreg = 1; wval = pc_q + hi20; end
            default: ;
        endcase
        if (wreg && widx == 5'd0) wreg = 0;
        if (!wreg) begin
            widx = 5'd0;
            wval = 32'd0;
        end else begin
            gpr[widx] = wval;
        end
        if (wmem) dmem[maddr[rieu_pkg::MemAw+1:2]] = mdata;
        pc_q = npc;
        res.next_pc       = npc;
        res.redirect      = taken;
        res.reg_write     = wreg;
        res.reg_index     = widx;
        res.reg_value     = wval;
        res.mem_write     = wmem;
        res.mem_address   = maddr;
        res.mem_data      = mdata;
        res.trap          = trap;
        res.at_breakpoint = (npc == brk_addr_q);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic send_item(rieu_pkg::t_op cmd, logic [4:0] rd, logic [4:0] rj,
                             logic [4:0] rk, logic [25:0] imm);
        rieu_pkg::t_in_item it;
        int       gap;
        it.command   = cmd;
        it.dest_reg  = rd;
        it.src_reg_a = rj;
        it.src_reg_b = rk;
        it.immediate = imm;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results = {pending_results, execute_item(it)};
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [31:0] idx, logic [31:0] data);
        rieu_pkg::t_cfg_item c;
        c.index = idx;
        c.data  = data;
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= c;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_START_ADDR) pc_q = data;
        else if (idx == REG_BREAK_ADDR) brk_addr_q = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed();
        // Operand set-up: r1 = 0x80000000, r2 = -1, r3 = 0x7fffffff.
        send_item(rieu_pkg::OP_LU12I, 5'd1, 5'd0, 5'd0, 26'h0080000);
        send_item(rieu_pkg::OP_ADDI,  5'd2, 5'd0, 5'd0, 26'h3FFFFFF);
        send_item(rieu_pkg::OP_LU12I, 5'd3, 5'd0, 5'd0, 26'h007FFFF);
        send_item(rieu_pkg::OP_ORI,   5'd3, 5'd3, 5'd0, 26'h0000FFF);
        // Signed overflow divide, then division by zero, then the high-half multiplies.
        send_item(rieu_pkg::OP_DIV,   5'd4, 5'd1, 5'd2, 26'd0);
        send_item(rieu_pkg::OP_MOD,   5'd5, 5'd1, 5'd2, 26'd0);
        send_item(rieu_pkg::OP_DIV,   5'd6, 5'd3, 5'd0, 26'd0);
        send_item(rieu_pkg::OP_MODU,  5'd7, 5'd3, 5'd0, 26'd0);
        send_item(rieu_pkg::OP_MULH,  5'd8, 5'd1, 5'd2, 26'd0);
        send_item(rieu_pkg::OP_MULHU, 5'd9, 5'd2, 5'd2, 26'd0);
        // A write to r0 is discarded.
        send_item(rieu_pkg::OP_ADD,   5'd0, 5'd1, 5'd3, 26'd0);
        // Misaligned stores and loads, and an address beyond the memory.
        send_item(rieu_pkg::OP_STW,   5'd3, 5'd0, 5'd0, 26'h00007FF);
        send_item(rieu_pkg::OP_STB,   5'd2, 5'd0, 5'd0, 26'h0000011);
        send_item(rieu_pkg::OP_STH,   5'd1, 5'd0, 5'd0, 26'h0000013);
        send_item(rieu_pkg::OP_LDB,   5'd10, 5'd0, 5'd0, 26'h0000011);
        send_item(rieu_pkg::OP_LDHU,  5'd11, 5'd0, 5'd0, 26'h0000013);
        send_item(rieu_pkg::OP_LDW,   5'd12, 5'd1, 5'd0, 26'h0000010);
        send_item(rieu_pkg::OP_SC,    5'd13, 5'd0, 5'd0, 26'h0001FFF);
        send_item(rieu_pkg::OP_LL,    5'd14, 5'd0, 5'd0, 26'h0001FFF);
        // jirl whose link register is also its base.
        send_item(rieu_pkg::OP_JIRL,  5'd3, 5'd3, 5'd0, 26'h0008000);
        send_item(rieu_pkg::OP_BL,    5'd0, 5'd0, 5'd0, 26'h2000000);
        send_item(rieu_pkg::OP_BREAK, 5'd0, 5'd0, 5'd0, 26'd0);
        send_item(rieu_pkg::OP_SYSCALL, 5'd0, 5'd0, 5'd0, 26'd0);
        send_item(rieu_pkg::OP_PRELD, 5'd5, 5'd5, 5'd5, 26'h3FFFFFF);
        send_item(rieu_pkg::t_op'(6'd63), 5'd31, 5'd31, 5'd31, 26'h1555555);
    endtask

    task automatic test_random(int count);
        rieu_pkg::t_op cmd;
        logic [4:0]  rd, rj, rk;
        logic [25:0] imm;
        int          r;
        repeat (count) begin
            r   = $urandom_range(99);
            rd  = 5'($urandom);
            rj  = 5'($urandom);
            rk  = 5'($urandom);
            imm = 26'($urandom);
            if (r < 8) begin
                cmd = rieu_pkg::t_op'(6'($urandom_range(63, 52)));
            end else if (r < 20) begin
                // Memory access near the bottom so that loads meet earlier stores.
                cmd = rieu_pkg::t_op'(6'($urandom_range(rieu_pkg::OP_LL + 1,
                                                        rieu_pkg::OP_LDB)));
                rj  = 5'd0;
                imm = 26'($urandom_range(255));
            end else if (r < 28) begin
                cmd = ($urandom_range(1)) ? rieu_pkg::OP_LU12I : rieu_pkg::OP_ORI;
            end else begin
                cmd = rieu_pkg::t_op'(6'($urandom_range(rieu_pkg::OP_PCADDU12I)));
            end
            send_item(cmd, rd, rj, rk, imm);
        end
    endtask

    task automatic test_config(logic [31:0] start_addr, logic [31:0] brk_addr);
        wait_drained();
        write_reg(REG_START_ADDR, start_addr);
        write_reg(REG_BREAK_ADDR, brk_addr);
    endtask

    // Output side: random back-pressure.
    initial begin
        int hold;
        hold = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) hold = ($urandom_range(2) == 0) ? pick_gap() : 0;
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        rieu_pkg::t_out_item got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result next_pc", got.next_pc, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.next_pc != want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.redirect != want.redirect)
                    report_mismatch("redirect", got.redirect, want.redirect);
                if (got.reg_write != want.reg_write)
                    report_mismatch("reg_write", got.reg_write, want.reg_write);
                if (got.reg_index != want.reg_index)
                    report_mismatch("reg_index", got.reg_index, want.reg_index);
                if (got.reg_value != want.reg_value)
                    report_mismatch("reg_value", got.reg_value, want.reg_value);
                if (got.mem_write != want.mem_write)
                    report_mismatch("mem_write", got.mem_write, want.mem_write);
                if (got.mem_address != want.mem_address)
                    report_mismatch("mem_address", got.mem_address, want.mem_address);
                if (got.mem_data != want.mem_data)
                    report_mismatch("mem_data", got.mem_data, want.mem_data);
                if (got.trap != want.trap)
                    report_mismatch("trap", got.trap, want.trap);
                if (got.at_breakpoint != want.at_breakpoint)
                    report_mismatch("at_breakpoint", got.at_breakpoint, want.at_breakpoint);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count    = 0;
        idle_cycles    = 0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        for (int i = 0; i < 32; i++) gpr[i] = 32'd0;
        for (int i = 0; i < rieu_pkg::MemWords; i++) dmem[i] = 32'd0;
        pc_q       = 32'd0;
        brk_addr_q = 32'd0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_config(32'd0, 32'd8);
        test_directed();
        test_config(32'hFFFF_FFFC, 32'd4);
        test_random(350);
        test_config(32'h0000_1000, 32'hFFFF_FFFF);
        test_random(350);
        test_config(32'hFFFF_FFFF, 32'h0000_0000);
        test_random(330);
        wait_drained();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
